### rtl/core/prt_pkg.sv
package prt_pkg;

  localparam int unsigned QueueDepth = 64;

  localparam int unsigned PtrW    = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW    = $clog2(QueueDepth + 1);
  localparam int unsigned SumW    = CntW + 1;
  localparam int unsigned OpW     = 2;
  localparam int unsigned TimeW   = 40;
  localparam int unsigned IdW     = 32;
  localparam int unsigned StatusW = 3;
  localparam int unsigned RemW    = 7;

  typedef enum logic [OpW-1:0] {
    OpIssue    = 2'd0,
    OpComplete = 2'd1,
    OpClear    = 2'd2
  } opcode_e;

  typedef enum logic [StatusW-1:0] {
    StatIssued     = 3'd0,
    StatIssuedDrop = 3'd1,
    StatCompleted  = 3'd2,
    StatUnknown    = 3'd3,
    StatCleared    = 3'd4
  } status_e;

  // memory commands from the pointer logic to the timestamp store
  typedef struct packed {
    logic             we;
    logic [PtrW-1:0]  waddr;
    logic [TimeW-1:0] wdata;
    logic             re;
    logic [PtrW-1:0]  raddr;
  } mem_cmd_t;

  // outcome of one accepted item
  typedef struct packed {
    logic            valid;       // result ready without a memory read
    logic            needs_read;  // completion hit, timestamp comes from the store
    status_e         status;
    logic [IdW-1:0]  assigned_id;
    logic [RemW-1:0] removed_count;
  } res_t;

  // sum of a position and an offset below twice the depth, folded back
  function automatic logic [PtrW-1:0] wrap_ptr(input logic [SumW-1:0] s);
    logic [SumW-1:0] t;
    t = s - SumW'(QueueDepth);
    if (s >= SumW'(QueueDepth)) begin
      return t[PtrW-1:0];
    end
    return s[PtrW-1:0];
  endfunction

  function automatic logic [RemW-1:0] to_rem(input logic [CntW-1:0] c);
    return RemW'({{RemW{1'b0}}, c});
  endfunction

endpackage

### rtl/core/prt_if.sv
interface prt_req_if;
  logic                       valid;
  logic                       ready;
  logic [prt_pkg::OpW-1:0]    opcode;
  logic [prt_pkg::TimeW-1:0]  request_time;
  logic [prt_pkg::IdW-1:0]    lookup_id;

  modport source (output valid, output opcode, output request_time, output lookup_id,
                  input ready);
  modport sink   (input valid, input opcode, input request_time, input lookup_id,
                  output ready);
endinterface

interface prt_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [prt_pkg::StatusW-1:0]  status;
  logic [prt_pkg::IdW-1:0]      assigned_id;
  logic [prt_pkg::TimeW-1:0]    original_time;
  logic [prt_pkg::RemW-1:0]     removed_count;

  modport source (output valid, output status, output assigned_id, output original_time,
                  output removed_count, input ready);
  modport sink   (input valid, input status, input assigned_id, input original_time,
                  input removed_count, output ready);
endinterface

### rtl/core/prt_store.sv
module prt_store (
  input  logic                      clk_i,
  input  prt_pkg::mem_cmd_t         cmd_i,
  output logic [prt_pkg::TimeW-1:0] rd_data_o
);

  logic [prt_pkg::TimeW-1:0] mem [prt_pkg::QueueDepth];
  logic [prt_pkg::TimeW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.we) begin
      mem[cmd_i.waddr] <= cmd_i.wdata;
    end
    if (cmd_i.re) begin
      rd_data_q <= mem[cmd_i.raddr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### rtl/core/prt_ctrl.sv
module prt_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      accept_i,
  input  logic [prt_pkg::OpW-1:0]   opcode_i,
  input  logic [prt_pkg::TimeW-1:0] request_time_i,
  input  logic [prt_pkg::IdW-1:0]   lookup_id_i,
  output prt_pkg::mem_cmd_t         mem_cmd_o,
  output prt_pkg::res_t             res_o
);

  logic [prt_pkg::PtrW-1:0] head_q, head_d;
  logic [prt_pkg::CntW-1:0] count_q, count_d;
  logic [prt_pkg::IdW-1:0]  oldest_q, oldest_d;
  logic [prt_pkg::IdW-1:0]  next_q, next_d;

  logic                     full;
  logic                     hit;
  logic [prt_pkg::IdW-1:0]  delta;
  logic [prt_pkg::CntW-1:0] delta_c;
  logic [prt_pkg::CntW-1:0] taken;
  logic [prt_pkg::PtrW-1:0] head_inc;
  logic [prt_pkg::PtrW-1:0] tail;
  logic [prt_pkg::PtrW-1:0] pos;
  logic [prt_pkg::PtrW-1:0] pos_inc;

  assign full     = (count_q == prt_pkg::CntW'(prt_pkg::QueueDepth));
  assign head_inc = prt_pkg::wrap_ptr(prt_pkg::SumW'(head_q) + prt_pkg::SumW'(1));
  assign tail     = prt_pkg::wrap_ptr(prt_pkg::SumW'(head_q) + prt_pkg::SumW'(count_q));

  // held ids are consecutive, so the offset from the oldest id is the slot offset
  assign delta    = lookup_id_i - oldest_q;
  assign hit      = (delta < prt_pkg::IdW'(count_q));
  assign delta_c  = delta[prt_pkg::CntW-1:0];
  assign taken    = delta_c + prt_pkg::CntW'(1);
  assign pos      = prt_pkg::wrap_ptr(prt_pkg::SumW'(head_q) + prt_pkg::SumW'(delta_c));
  assign pos_inc  = prt_pkg::wrap_ptr(prt_pkg::SumW'(pos) + prt_pkg::SumW'(1));

  always_comb begin
    head_d              = head_q;
    count_d             = count_q;
    oldest_d            = oldest_q;
    next_d              = next_q;
    mem_cmd_o.we        = 1'b0;
    mem_cmd_o.waddr     = tail;
    mem_cmd_o.wdata     = request_time_i;
    mem_cmd_o.re        = 1'b0;
    mem_cmd_o.raddr     = pos;
    res_o.valid         = 1'b0;
    res_o.needs_read    = 1'b0;
    res_o.status        = prt_pkg::StatUnknown;
    res_o.assigned_id   = '0;
    res_o.removed_count = '0;
    unique case (prt_pkg::opcode_e'(opcode_i))
      prt_pkg::OpIssue: begin
        res_o.valid       = 1'b1;
        res_o.assigned_id = next_q;
        mem_cmd_o.we      = accept_i;
        next_d            = next_q + prt_pkg::IdW'(1);
        if (full) begin
          // drop the oldest, the new entry lands in its slot
          mem_cmd_o.waddr     = head_q;
          head_d              = head_inc;
          oldest_d            = oldest_q + prt_pkg::IdW'(1);
          res_o.status        = prt_pkg::StatIssuedDrop;
          res_o.removed_count = prt_pkg::RemW'(1);
        end else begin
          count_d      = count_q + prt_pkg::CntW'(1);
          res_o.status = prt_pkg::StatIssued;
          if (count_q == '0) begin
            oldest_d = next_q;
          end
        end
      end
      prt_pkg::OpComplete: begin
        if (hit) begin
          res_o.needs_read    = 1'b1;
          res_o.status        = prt_pkg::StatCompleted;
          res_o.removed_count = prt_pkg::to_rem(taken);
          mem_cmd_o.re        = accept_i;
          head_d              = pos_inc;
          count_d             = count_q - taken;
          oldest_d            = oldest_q + prt_pkg::IdW'(taken);
        end else begin
          res_o.valid = 1'b1;
        end
      end
      prt_pkg::OpClear: begin
        res_o.valid         = 1'b1;
        res_o.status        = prt_pkg::StatCleared;
        res_o.removed_count = prt_pkg::to_rem(count_q);
        count_d             = '0;
        oldest_d            = next_q;
      end
      default: begin
        // unused opcode: no result, no change
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      count_q  <= '0;
      oldest_q <= '0;
      next_q   <= '0;
    end else if (accept_i) begin
      head_q   <= head_d;
      count_q  <= count_d;
      oldest_q <= oldest_d;
      next_q   <= next_d;
    end
  end

endmodule

### rtl/core/pending_request_tracker_core.sv
// pending request tracker
//
// req_i carries one item per transfer: opcode (issue, complete, clear),
// request_time for issues and lookup_id for completions. rsp_o returns one
// result per item (status, assigned_id, original_time, removed_count); the
// unused opcode is taken and gives no result.
// issue, clear and completion of an unknown id: the result sits in the output
// register in the cycle after the transfer, and the next item can be taken in
// that cycle while the receiver is ready, so these run at one item per cycle.
// completion of a held id: the stored timestamp passes through the memory read
// register and then the output register; no item is taken during the read cycle.
// timestamps live in a QueueDepth-entry memory with one write and one read
// port; pointers, fill count and id counters sit in flip-flops.
// reset clears pointers, count and both id counters at once; the memory is
// not cleared since only written entries are ever read. no sweep is needed.
// a stalled receiver holds the result in the output register; a new item is
// taken only in the cycle the waiting result transfers or once it has gone.
module pending_request_tracker_core (
  input  logic   clk_i,
  input  logic   rst_ni,
  prt_req_if.sink   req_i,
  prt_rsp_if.source rsp_o
);

  typedef enum logic {
    StateIdle,
    StateRead
  } state_e;

  state_e                    state_q;
  logic                      accept;
  logic                      in_ready;
  prt_pkg::mem_cmd_t         mem_cmd;
  prt_pkg::res_t             res;
  logic [prt_pkg::TimeW-1:0] rd_data;

  // output register and the removed count held across the memory read
  logic                        rsp_valid_q;
  prt_pkg::status_e            rsp_status_q;
  logic [prt_pkg::IdW-1:0]     rsp_id_q;
  logic [prt_pkg::TimeW-1:0]   rsp_time_q;
  logic [prt_pkg::RemW-1:0]    rsp_removed_q;
  logic [prt_pkg::RemW-1:0]    pend_removed_q;

  // free output slot or one that transfers at this edge
  assign in_ready = (state_q == StateIdle) && (!rsp_valid_q || rsp_o.ready);
  assign accept   = req_i.valid && in_ready;

  prt_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .opcode_i       (req_i.opcode),
    .request_time_i (req_i.request_time),
    .lookup_id_i    (req_i.lookup_id),
    .mem_cmd_o      (mem_cmd),
    .res_o          (res)
  );

  prt_store u_store (
    .clk_i     (clk_i),
    .cmd_i     (mem_cmd),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= StateIdle;
      rsp_valid_q    <= 1'b0;
      rsp_status_q   <= prt_pkg::StatIssued;
      rsp_id_q       <= '0;
      rsp_time_q     <= '0;
      rsp_removed_q  <= '0;
      pend_removed_q <= '0;
    end else begin
      unique case (state_q)
        StateIdle: begin
          if (accept && res.needs_read) begin
            // output slot is free by the end of this cycle
            state_q        <= StateRead;
            pend_removed_q <= res.removed_count;
            if (rsp_o.ready) begin
              rsp_valid_q <= 1'b0;
            end
          end else if (accept && res.valid) begin
            rsp_valid_q   <= 1'b1;
            rsp_status_q  <= res.status;
            rsp_id_q      <= res.assigned_id;
            rsp_time_q    <= '0;
            rsp_removed_q <= res.removed_count;
          end else if (rsp_o.ready) begin
            rsp_valid_q <= 1'b0;
          end
        end
        StateRead: begin
          // stored timestamp arrives from the memory read register
          state_q       <= StateIdle;
          rsp_valid_q   <= 1'b1;
          rsp_status_q  <= prt_pkg::StatCompleted;
          rsp_id_q      <= '0;
          rsp_time_q    <= rd_data;
          rsp_removed_q <= pend_removed_q;
        end
        default: begin
          state_q <= StateIdle;
        end
      endcase
    end
  end

  assign req_i.ready         = in_ready;
  assign rsp_o.valid         = rsp_valid_q;
  assign rsp_o.status        = rsp_status_q;
  assign rsp_o.assigned_id   = rsp_id_q;
  assign rsp_o.original_time = rsp_time_q;
  assign rsp_o.removed_count = rsp_removed_q;

  // the read cycle only starts with an empty output register
  a_read_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StateRead) |-> !rsp_valid_q)
    else $error("output register busy during memory read");

  // a held-id completion enters the read cycle
  a_hit_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && res.needs_read) |=> (state_q == StateRead) && $past(mem_cmd.re))
    else $error("completion hit did not read the store");

  // completion always removes at least the matched entry
  a_completed_removes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && (rsp_status_q == prt_pkg::StatCompleted)) |-> (rsp_removed_q != '0))
    else $error("completion with nothing removed");

  // ids are given only to issues
  a_id_only_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && (rsp_status_q != prt_pkg::StatIssued)
     && (rsp_status_q != prt_pkg::StatIssuedDrop)) |-> (rsp_id_q == '0))
    else $error("id given on a non-issue result");

endmodule
